>>> sv/bdlp_pkg.sv
package bdlp_pkg;

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_EDGE    = 2'd0,
        KIND_POLL    = 2'd1,
        KIND_SUSPEND = 2'd2,
        KIND_RESUME  = 2'd3
    } t_kind;

    // Brightness action codes.
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_STEP = 2'd1,
        ACT_JUMP = 2'd2
    } t_action;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DEBOUNCE_MS   = 3'd0;
    localparam logic [2:0] CFG_LONG_PRESS_MS = 3'd1;
    localparam logic [2:0] CFG_LAYOUT_PIN    = 3'd2;
    localparam logic [2:0] CFG_THEME_PIN     = 3'd3;
    localparam logic [2:0] CFG_UP_PIN        = 3'd4;
    localparam logic [2:0] CFG_DOWN_PIN      = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_DEBOUNCE_MS   = 16'd250;
    localparam logic [15:0] RST_LONG_PRESS_MS = 16'd2000;
    localparam logic [6:0]  RST_LAYOUT_PIN    = 7'd48;
    localparam logic [6:0]  RST_THEME_PIN     = 7'd46;
    localparam logic [6:0]  RST_UP_PIN        = 7'd47;
    localparam logic [6:0]  RST_DOWN_PIN      = 7'd49;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [1:0]  port;
        logic [4:0]  pin;
        logic        up_held;
        logic        down_held;
        logic        standby;
        logic        layout_ready;
    } t_in_item;

    typedef struct packed {
        logic       edge_accepted;
        logic       layout_advance;
        logic       theme_advance;
        logic [1:0] up_action;
        logic [1:0] down_action;
    } t_out_item;

    // Classify a pending brightness press at a poll.
    function automatic t_action classify(
        input logic        pending,
        input logic        held,
        input logic [31:0] elapsed,
        input logic [15:0] long_ms,
        input logic [15:0] deb_ms
    );
        t_action act;
        act = ACT_NONE;
        if (pending) begin
            if (held && (elapsed >= {16'd0, long_ms})) begin
                act = ACT_JUMP;
            end else if (!held && (elapsed >= {16'd0, deb_ms})) begin
                act = ACT_STEP;
            end
        end
        return act;
    endfunction

endpackage

>>> sv/bdlp_table.sv
module bdlp_table import bdlp_pkg::*; #(
    parameter int DEPTH = 96,
    parameter int IDX_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  logic [IDX_W-1:0] i_cur_idx,
    input  logic             i_adv,
    input  logic             i_wr_en,
    input  logic [31:0]      i_wr_data,
    output logic [31:0]      o_rd_time
);

    logic [31:0]      r_mem [DEPTH];
    logic             r_vld [DEPTH];
    logic [31:0]      r_rd_data;
    logic             r_rd_vld;
    logic             r_fwd_vld;
    logic [IDX_W-1:0] r_fwd_idx;
    logic [31:0]      r_fwd_data;
    logic             w_wr;

    assign w_wr = i_adv && i_wr_en;

    // Time memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[i_cur_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Per-entry valid bits; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (w_wr) begin
                r_vld[i_cur_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    // Forwarding register holds the write of the last item that left the compute stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (i_adv) begin
            r_fwd_vld <= i_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_fwd_idx  <= i_cur_idx;
            r_fwd_data <= i_wr_data;
        end
    end

    // A write in the same cycle as the read is not seen by the memory, so bypass it.
    always_comb begin
        if (r_fwd_vld && (r_fwd_idx == i_cur_idx)) begin
            o_rd_time = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_time = r_rd_data;
        end else begin
            o_rd_time = 32'd0;
        end
    end

endmodule

>>> sv/button_debounce_long_press.sv
// Button debounce and long-press classifier.
// The input channel carries one item per event: a button edge (port, pin),
// a poll tick with button levels and standby state, or a suspend or resume
// of the layout and theme buttons. Every item produces exactly one result
// item on the output channel, in order. Configuration registers are written
// through a separate channel, which is always ready; the user must write
// them only while the block is idle, and the block does not enforce this.
// The compute stage registers the item, the output register its result.
// Throughput: one item per cycle unless the receiver stalls. The per-pin
// last-accept time table is a memory with a registered read; the read is
// done on acceptance and the write-back as the item leaves the compute
// stage; a bypass register covers an edge on the same pin in the next item.
// Reset clears the configuration to its defaults, all pending requests and
// the press times; per-entry valid bits make the table read as zero at once,
// so no clearing pass is needed and items are taken right after reset.
// When the receiver stalls, the output register holds its result, one more
// item waits in the compute stage, and then the input stops being ready.
module button_debounce_long_press import bdlp_pkg::*; #(
    parameter int PORT_COUNT    = 3,
    parameter int PINS_PER_PORT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int DEPTH = PORT_COUNT * PINS_PER_PORT;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers.
    logic [15:0] r_debounce_ms;
    logic [15:0] r_long_press_ms;
    logic [6:0]  r_layout_pin;
    logic [6:0]  r_theme_pin;
    logic [6:0]  r_up_pin;
    logic [6:0]  r_down_pin;

    // Block state.
    logic        r_layout_pending, n_layout_pending;
    logic        r_theme_pending,  n_theme_pending;
    logic        r_up_pending,     n_up_pending;
    logic        r_down_pending,   n_down_pending;
    logic [31:0] r_up_press_time,  n_up_press_time;
    logic [31:0] r_down_press_time, n_down_press_time;
    logic        r_ui_suspended,   n_ui_suspended;

    // Compute stage and output register.
    logic             r_s1_valid;
    t_in_item         r_s1_item;
    logic             r_s1_in_range;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    logic             w_in_acc;
    logic             w_s1_adv;
    logic             w_in_range;
    logic [IDX_W-1:0] w_idx;
    logic [31:0]      w_tbl_time;
    logic [31:0]      w_edge_elapsed;
    logic             w_accept;
    logic [6:0]       w_code;
    t_action          w_up_act;
    t_action          w_down_act;

    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= RST_DEBOUNCE_MS;
            r_long_press_ms <= RST_LONG_PRESS_MS;
            r_layout_pin    <= RST_LAYOUT_PIN;
            r_theme_pin     <= RST_THEME_PIN;
            r_up_pin        <= RST_UP_PIN;
            r_down_pin      <= RST_DOWN_PIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                CFG_LAYOUT_PIN:    r_layout_pin    <= i_cfg_data[6:0];
                CFG_THEME_PIN:     r_theme_pin     <= i_cfg_data[6:0];
                CFG_UP_PIN:        r_up_pin        <= i_cfg_data[6:0];
                CFG_DOWN_PIN:      r_down_pin      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Handshake: the compute stage moves on when the output register is free.
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Table index of the incoming edge; only meaningful when the pin is in range.
    assign w_in_range = (32'(i_in_item.port) < 32'(PORT_COUNT))
                     && (32'(i_in_item.pin) < 32'(PINS_PER_PORT));
    assign w_idx = IDX_W'(i_in_item.port) * IDX_W'(PINS_PER_PORT) + IDX_W'(i_in_item.pin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_item     <= i_in_item;
            r_s1_in_range <= w_in_range;
            r_s1_idx      <= w_idx;
        end
    end

    // Last-accept time table with read-modify-write bypass.
    bdlp_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_idx  (w_idx),
        .i_cur_idx (r_s1_idx),
        .i_adv     (w_s1_adv),
        .i_wr_en   (w_accept),
        .i_wr_data (r_s1_item.now_ms),
        .o_rd_time (w_tbl_time)
    );

    // Debounce lockout and brightness classification.
    assign w_edge_elapsed = r_s1_item.now_ms - w_tbl_time;
    assign w_accept = (t_kind'(r_s1_item.kind) == KIND_EDGE) && r_s1_in_range
                   && (w_edge_elapsed >= {16'd0, r_debounce_ms});
    assign w_code = {r_s1_item.port, r_s1_item.pin};

    assign w_up_act = classify(r_up_pending, r_s1_item.up_held,
                               r_s1_item.now_ms - r_up_press_time,
                               r_long_press_ms, r_debounce_ms);
    assign w_down_act = classify(r_down_pending, r_s1_item.down_held,
                                 r_s1_item.now_ms - r_down_press_time,
                                 r_long_press_ms, r_debounce_ms);

    // Next state and result of the item in the compute stage.
    always_comb begin
        n_layout_pending  = r_layout_pending;
        n_theme_pending   = r_theme_pending;
        n_up_pending      = r_up_pending;
        n_down_pending    = r_down_pending;
        n_up_press_time   = r_up_press_time;
        n_down_press_time = r_down_press_time;
        n_ui_suspended    = r_ui_suspended;
        n_out_item        = '0;
        case (t_kind'(r_s1_item.kind))
            KIND_EDGE: begin
                if (w_accept) begin
                    n_out_item.edge_accepted = 1'b1;
                    // First matching code wins: layout, theme, up, down.
                    if (w_code == r_layout_pin) begin
                        if (!r_ui_suspended) begin
                            n_layout_pending = 1'b1;
                        end
                    end else if (w_code == r_theme_pin) begin
                        if (!r_ui_suspended) begin
                            n_theme_pending = 1'b1;
                        end
                    end else if (w_code == r_up_pin) begin
                        n_up_press_time = r_s1_item.now_ms;
                        n_up_pending    = 1'b1;
                    end else if (w_code == r_down_pin) begin
                        n_down_press_time = r_s1_item.now_ms;
                        n_down_pending    = 1'b1;
                    end
                end
            end
            KIND_POLL: begin
                if (r_s1_item.standby) begin
                    n_layout_pending = 1'b0;
                    n_theme_pending  = 1'b0;
                end else begin
                    if (r_layout_pending && r_s1_item.layout_ready) begin
                        n_layout_pending          = 1'b0;
                        n_out_item.layout_advance = 1'b1;
                    end
                    if (r_theme_pending && r_s1_item.layout_ready) begin
                        n_theme_pending          = 1'b0;
                        n_out_item.theme_advance = 1'b1;
                    end
                end
                n_out_item.up_action   = w_up_act;
                n_out_item.down_action = w_down_act;
                if (w_up_act != ACT_NONE) begin
                    n_up_pending = 1'b0;
                end
                if (w_down_act != ACT_NONE) begin
                    n_down_pending = 1'b0;
                end
            end
            KIND_SUSPEND: begin
                n_ui_suspended   = 1'b1;
                n_layout_pending = 1'b0;
                n_theme_pending  = 1'b0;
            end
            default: begin
                n_ui_suspended   = 1'b0;
                n_layout_pending = 1'b0;
                n_theme_pending  = 1'b0;
            end
        endcase
    end

    // State update when the item leaves the compute stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_pending  <= 1'b0;
            r_theme_pending   <= 1'b0;
            r_up_pending      <= 1'b0;
            r_down_pending    <= 1'b0;
            r_up_press_time   <= 32'd0;
            r_down_press_time <= 32'd0;
            r_ui_suspended    <= 1'b0;
        end else if (w_s1_adv) begin
            r_layout_pending  <= n_layout_pending;
            r_theme_pending   <= n_theme_pending;
            r_up_pending      <= n_up_pending;
            r_down_pending    <= n_down_pending;
            r_up_press_time   <= n_up_press_time;
            r_down_press_time <= n_down_press_time;
            r_ui_suspended    <= n_ui_suspended;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
